@@ hw/rtl/dehv_pkg.sv @@
// ----------------------------------------------------------------------------
// dehv_pkg
// Shared types and constants for the exception-header value decoder:
// field widths, input function codes, encodings, command and mode types.
// ----------------------------------------------------------------------------
`default_nettype none

package dehv_pkg;

    // field widths
    localparam int FUNC_W    = 2;
    localparam int ENC_W     = 8;
    localparam int BYTE_W    = 8;
    localparam int VALUE_W   = 64;
    localparam int S_TDATA_W = 16;
    localparam int SHIFT_W   = 7;
    localparam int LEFT_W    = 4;

    // command queue depth between front and back
    localparam int QUEUE_DEPTH = 4;

    // leb128 payload bits per byte and shift stop
    localparam int LEB_BITS   = 7;
    localparam int SHIFT_STOP = 70;

    // input function codes
    localparam logic [FUNC_W-1:0] FUNC_BEGIN = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DATA  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_END   = 2'd2;

    // encoding low nibble codes
    localparam logic [3:0] ENC_ULEB  = 4'h1;
    localparam logic [3:0] ENC_SLEB  = 4'h9;
    localparam logic [3:0] ENC_UDAT2 = 4'h2;
    localparam logic [3:0] ENC_SDAT2 = 4'hA;
    localparam logic [3:0] ENC_UDAT4 = 4'h3;
    localparam logic [3:0] ENC_SDAT4 = 4'hB;
    localparam logic [3:0] ENC_UDAT8 = 4'h4;
    localparam logic [3:0] ENC_SDAT8 = 4'hC;

    // byte counts of fixed fields
    localparam logic [LEFT_W-1:0] FIX2_BYTES = 4'd2;
    localparam logic [LEFT_W-1:0] FIX4_BYTES = 4'd4;
    localparam logic [LEFT_W-1:0] FIX8_BYTES = 4'd8;

    // result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_DATA  = 2'd1,
        OP_END   = 2'd2
    } t_op;

    // decode mode, one-hot
    typedef enum logic [5:0] {
        MODE_IDLE = 6'b000001,
        MODE_ULEB = 6'b000010,
        MODE_SLEB = 6'b000100,
        MODE_FIX2 = 6'b001000,
        MODE_FIX4 = 6'b010000,
        MODE_FIX8 = 6'b100000
    } t_mode;

    // classified command from front to back
    typedef struct packed {
        t_op               op;
        t_mode             mode;
        logic [BYTE_W-1:0] data;
    } t_cmd;

endpackage

`default_nettype wire

@@ hw/rtl/dwarf_eh_value_decoder.sv @@
// a result is offered from the output register after the item that completes it has passed through the command queue
// throughput: one item per cycle; the back executes one queued command each cycle unless the sink holds the output
// the front stalls only in reset or when the command queue is full (output held by the sink)
// reset: synchronous active-low i_rst_n clears the queue, decode mode, byte_swap
// and the output valid; input ready is low during reset, no clearing pass
// ----------------------------------------------------------------------------
// dwarf_eh_value_decoder
// Decodes exception-header encoded values (leb128 and fixed fields) from a
// byte stream: front classifier, command queue, execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dwarf_eh_value_decoder #(
    parameter int QUEUE_DEPTH = dehv_pkg::QUEUE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_wdata,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // encoding [7:0], data_byte [15:8]
    input  wire logic [dehv_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // func [1:0]
    input  wire logic [dehv_pkg::FUNC_W-1:0]    i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // value [63:0]
    output logic [dehv_pkg::VALUE_W-1:0]        o_m_axis_tdata,
    // status [0]
    output logic                                o_m_axis_tuser
);

    logic           w_full;
    logic           w_push;
    dehv_pkg::t_cmd w_push_cmd;
    logic           w_pop;
    logic           w_q_valid;
    dehv_pkg::t_cmd w_q_cmd;

    // front: accept and classify
    dehv_front u_front (
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_full          (w_full),
        .o_push          (w_push),
        .o_cmd           (w_push_cmd)
    );

    // command queue
    dehv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // back: execute and hold results
    dehv_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (w_q_valid),
        .i_cmd           (w_q_cmd),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

@@ hw/rtl/dehv_front.sv @@
// ----------------------------------------------------------------------------
// dehv_front
// Input side: takes stream transfers, drops unused function codes and turns
// each item into a classified command for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dehv_front (
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // encoding [7:0], data_byte [15:8]
    input  wire logic [dehv_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // func [1:0]
    input  wire logic [dehv_pkg::FUNC_W-1:0]    i_s_axis_tuser,
    input  wire logic                           i_full,
    output logic                                o_push,
    output dehv_pkg::t_cmd                      o_cmd
);

    logic [3:0]                     w_enc;
    logic [dehv_pkg::BYTE_W-1:0]    w_byte;
    logic                           w_known;

    assign w_enc  = i_s_axis_tdata[3:0];
    assign w_byte = i_s_axis_tdata[dehv_pkg::ENC_W +: dehv_pkg::BYTE_W];

    // accept whenever the queue has room, never while in reset
    assign o_s_axis_tready = i_rst_n && !i_full;

    // classify the item
    always_comb begin
        o_cmd.data = w_byte;
        o_cmd.op   = dehv_pkg::OP_DATA;
        o_cmd.mode = dehv_pkg::MODE_IDLE;
        w_known    = 1'b1;
        case (i_s_axis_tuser)
            dehv_pkg::FUNC_BEGIN: begin
                o_cmd.op = dehv_pkg::OP_BEGIN;
                case (w_enc)
                    dehv_pkg::ENC_ULEB:  o_cmd.mode = dehv_pkg::MODE_ULEB;
                    dehv_pkg::ENC_SLEB:  o_cmd.mode = dehv_pkg::MODE_SLEB;
                    dehv_pkg::ENC_UDAT2: o_cmd.mode = dehv_pkg::MODE_FIX2;
                    dehv_pkg::ENC_SDAT2: o_cmd.mode = dehv_pkg::MODE_FIX2;
                    dehv_pkg::ENC_UDAT4: o_cmd.mode = dehv_pkg::MODE_FIX4;
                    dehv_pkg::ENC_SDAT4: o_cmd.mode = dehv_pkg::MODE_FIX4;
                    dehv_pkg::ENC_UDAT8: o_cmd.mode = dehv_pkg::MODE_FIX8;
                    dehv_pkg::ENC_SDAT8: o_cmd.mode = dehv_pkg::MODE_FIX8;
                    default:             o_cmd.mode = dehv_pkg::MODE_IDLE;
                endcase
            end
            dehv_pkg::FUNC_DATA: begin
                o_cmd.op = dehv_pkg::OP_DATA;
            end
            dehv_pkg::FUNC_END: begin
                o_cmd.op = dehv_pkg::OP_END;
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
    end

    // unused function code is consumed without a command
    assign o_push = i_s_axis_tvalid && o_s_axis_tready && w_known;

endmodule

`default_nettype wire

@@ hw/rtl/dehv_queue.sv @@
// ----------------------------------------------------------------------------
// dehv_queue
// Small command queue between the front and the back, so each side can
// stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module dehv_queue #(
    parameter int DEPTH = dehv_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire dehv_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output dehv_pkg::t_cmd      o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dehv_pkg::t_cmd     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               w_do_push;
    logic               w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_cmd     = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dehv_back.sv @@
// ----------------------------------------------------------------------------
// dehv_back
// Execution side: runs the leb128 and fixed-field assembly one command per
// cycle while the output register is free or being taken, and holds each result there until transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module dehv_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_wdata,
    input  wire logic                         i_valid,
    input  wire dehv_pkg::t_cmd               i_cmd,
    output logic                              o_pop,
    output logic                              o_m_axis_tvalid,
    input  wire logic                         i_m_axis_tready,
    // value [63:0]
    output logic [dehv_pkg::VALUE_W-1:0]      o_m_axis_tdata,
    // status [0]
    output logic                              o_m_axis_tuser
);

    localparam int VW = dehv_pkg::VALUE_W;
    localparam int SW = dehv_pkg::SHIFT_W;
    localparam int BW = dehv_pkg::BYTE_W;
    localparam int LB = dehv_pkg::LEB_BITS;

    logic                           r_swap;
    dehv_pkg::t_mode                r_mode, n_mode;
    logic [VW-1:0]                  r_acc, n_acc;
    logic [SW-1:0]                  r_shift, n_shift;
    logic [dehv_pkg::LEFT_W-1:0]    r_left, n_left;
    logic                           r_out_valid;
    logic [VW-1:0]                  r_out_value;
    logic                           r_out_status;

    logic                           w_res_valid;
    logic [VW-1:0]                  w_res_value;
    logic                           w_res_status;
    logic [SW-1:0]                  w_leb_shift;
    logic [SW-1:0]                  w_fix_shift;
    logic                           w_shift_in;
    logic [VW-1:0]                  w_leb_acc;
    logic [VW-1:0]                  w_fix_acc;
    logic [dehv_pkg::LEFT_W-1:0]    w_fix_left;

    assign o_pop           = i_valid && (!r_out_valid || i_m_axis_tready);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_status;

    // shared datapath terms
    always_comb begin
        w_shift_in  = (r_shift < SW'(VW));
        w_leb_shift = r_shift + SW'(LB);
        w_fix_shift = ((r_shift + SW'(BW)) > SW'(dehv_pkg::SHIFT_STOP))
                      ? SW'(dehv_pkg::SHIFT_STOP) : (r_shift + SW'(BW));
        w_leb_acc   = r_acc | ({{(VW-LB){1'b0}}, i_cmd.data[LB-1:0]}
                               << r_shift[$clog2(VW)-1:0]);
        if (r_swap) begin
            w_fix_acc = {r_acc[VW-BW-1:0], i_cmd.data};
        end else if (w_shift_in) begin
            w_fix_acc = r_acc | ({{(VW-BW){1'b0}}, i_cmd.data}
                                 << r_shift[$clog2(VW)-1:0]);
        end else begin
            w_fix_acc = r_acc;
        end
        w_fix_left = (r_left != '0) ? r_left - 1'b1 : r_left;
    end

    // command execution
    always_comb begin
        n_mode       = r_mode;
        n_acc        = r_acc;
        n_shift      = r_shift;
        n_left       = r_left;
        w_res_valid  = 1'b0;
        w_res_value  = '0;
        w_res_status = dehv_pkg::STATUS_OK;
        case (i_cmd.op)
            dehv_pkg::OP_BEGIN: begin
                n_acc   = '0;
                n_shift = '0;
                n_mode  = i_cmd.mode;
                case (i_cmd.mode)
                    dehv_pkg::MODE_FIX2: n_left = dehv_pkg::FIX2_BYTES;
                    dehv_pkg::MODE_FIX4: n_left = dehv_pkg::FIX4_BYTES;
                    dehv_pkg::MODE_FIX8: n_left = dehv_pkg::FIX8_BYTES;
                    default:             n_left = '0;
                endcase
                // unknown encoding answers zero at once
                if (i_cmd.mode == dehv_pkg::MODE_IDLE) begin
                    w_res_valid = 1'b1;
                end
            end
            dehv_pkg::OP_END: begin
                if (r_mode != dehv_pkg::MODE_IDLE) begin
                    n_mode       = dehv_pkg::MODE_IDLE;
                    n_acc        = '0;
                    n_shift      = '0;
                    n_left       = '0;
                    w_res_valid  = 1'b1;
                    w_res_status = dehv_pkg::STATUS_ERR;
                end
            end
            dehv_pkg::OP_DATA: begin
                case (r_mode)
                    dehv_pkg::MODE_ULEB, dehv_pkg::MODE_SLEB: begin
                        if (w_shift_in) begin
                            n_acc   = w_leb_acc;
                            n_shift = w_leb_shift;
                        end
                        // last byte has the continuation bit clear
                        if (!i_cmd.data[BW-1]) begin
                            if (r_mode == dehv_pkg::MODE_SLEB && i_cmd.data[LB-1]
                                && n_shift < SW'(VW)) begin
                                n_acc = n_acc | ({VW{1'b1}} << n_shift[$clog2(VW)-1:0]);
                            end
                            n_mode      = dehv_pkg::MODE_IDLE;
                            w_res_valid = 1'b1;
                            w_res_value = n_acc;
                        end
                    end
                    dehv_pkg::MODE_FIX2, dehv_pkg::MODE_FIX4,
                    dehv_pkg::MODE_FIX8: begin
                        n_acc  = w_fix_acc;
                        n_left = w_fix_left;
                        if (!r_swap) begin
                            n_shift = w_fix_shift;
                        end
                        if (w_fix_left == '0) begin
                            n_mode      = dehv_pkg::MODE_IDLE;
                            w_res_valid = 1'b1;
                            // fixed fields are sign-extended from their width
                            if (r_mode == dehv_pkg::MODE_FIX2) begin
                                w_res_value = {{(VW-16){w_fix_acc[15]}}, w_fix_acc[15:0]};
                            end else if (r_mode == dehv_pkg::MODE_FIX4) begin
                                w_res_value = {{(VW-32){w_fix_acc[31]}}, w_fix_acc[31:0]};
                            end else begin
                                w_res_value = w_fix_acc;
                            end
                        end
                    end
                    default: begin
                        // data byte while idle is ignored
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // decode state, config and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap      <= 1'b0;
            r_mode      <= dehv_pkg::MODE_IDLE;
            r_acc       <= '0;
            r_shift     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_swap <= i_cfg_wdata;
            end
            if (o_pop) begin
                r_mode  <= n_mode;
                r_acc   <= n_acc;
                r_shift <= n_shift;
                r_left  <= n_left;
            end
            if (o_pop && w_res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop && w_res_valid) begin
            r_out_value  <= w_res_value;
            r_out_status <= w_res_status;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dehv_checker.sv @@
// ----------------------------------------------------------------------------
// dehv_checker
// Port-level checks on the decoder's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dehv_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_m_axis_tvalid,
    input wire logic                           i_m_axis_tready,
    input wire logic [dehv_pkg::VALUE_W-1:0]   o_m_axis_tdata,
    input wire logic                           o_m_axis_tuser
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value and status
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
        |=> $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // a read error always carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == dehv_pkg::STATUS_ERR)
        |-> o_m_axis_tdata == '0)
        else $error("read error with nonzero value");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result offered after reset");

endmodule

bind dwarf_eh_value_decoder dehv_checker u_dehv_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the exception-header value decoder. A scoreboard
// class predicts every decoded value from the accepted input transfers and
// compares the output stream field by field. Directed corner cases come first,
// then phases of random leb128 and fixed-field values with both byte orders,
// random idling on both stream sides and a drain before each phase's register write.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 9;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 125;
    localparam int TAIL_CYCLES  = 8;
    localparam int STUCK_LIMIT  = 2000;
    localparam int VW           = dehv_pkg::VALUE_W;
    localparam int SHW          = dehv_pkg::SHIFT_W;
    localparam int FW           = dehv_pkg::FUNC_W;
    localparam int EW           = dehv_pkg::ENC_W;
    localparam int BW           = dehv_pkg::BYTE_W;

    localparam logic [FW-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [3:0]    ENC_UNKNOWN = 4'hF;
    localparam logic [3:0]    KNOWN_CODES [8] = '{
        dehv_pkg::ENC_ULEB,  dehv_pkg::ENC_SLEB,  dehv_pkg::ENC_UDAT2, dehv_pkg::ENC_SDAT2,
        dehv_pkg::ENC_UDAT4, dehv_pkg::ENC_SDAT4, dehv_pkg::ENC_UDAT8, dehv_pkg::ENC_SDAT8};

    typedef struct {
        logic [VW-1:0] value;
        logic          status;
    } t_decode_result;

    // predicts decoded values and holds the ones still owed by the block
    class value_scoreboard;
        logic                              swap;
        logic                              busy;
        dehv_pkg::t_mode                   mode;
        logic [VW-1:0]                     acc;
        logic [SHW-1:0]                    shift;
        logic [dehv_pkg::LEFT_W-1:0]       left;
        t_decode_result                    expected_values[$];
        int errors;
        int n_checked;
        int n_values;
        int n_unknown;
        int n_read_errors;

        function new();
            swap = 1'b0;
            busy = 1'b0;
            mode = dehv_pkg::MODE_IDLE;
            acc = '0;
            shift = '0;
            left = '0;
        endfunction

        function void set_swap(logic value);
            swap = value;
        endfunction

        function int pending();
            return expected_values.size();
        endfunction

        function void add_expected(logic [VW-1:0] value, logic status);
            t_decode_result r;
            r.value = value;
            r.status = status;
            expected_values.insert(expected_values.size(), r);
        endfunction

        // advance the decode state by one accepted input transfer
        function void note_item(logic [FW-1:0] func, logic [EW-1:0] enc,
                                logic [BW-1:0] b);
            logic [VW-1:0] result;
            int            next_shift;
            if (func == dehv_pkg::FUNC_BEGIN) begin
                acc = '0;
                shift = '0;
                left = '0;
                busy = 1'b1;
                case (enc[3:0])
                    dehv_pkg::ENC_ULEB: mode = dehv_pkg::MODE_ULEB;
                    dehv_pkg::ENC_SLEB: mode = dehv_pkg::MODE_SLEB;
                    dehv_pkg::ENC_UDAT2, dehv_pkg::ENC_SDAT2: begin
                        mode = dehv_pkg::MODE_FIX2;
                        left = dehv_pkg::FIX2_BYTES;
                    end
                    dehv_pkg::ENC_UDAT4, dehv_pkg::ENC_SDAT4: begin
                        mode = dehv_pkg::MODE_FIX4;
                        left = dehv_pkg::FIX4_BYTES;
                    end
                    dehv_pkg::ENC_UDAT8, dehv_pkg::ENC_SDAT8: begin
                        mode = dehv_pkg::MODE_FIX8;
                        left = dehv_pkg::FIX8_BYTES;
                    end
                    default: begin
                        mode = dehv_pkg::MODE_IDLE;
                        busy = 1'b0;
                        n_unknown++;
                        add_expected('0, dehv_pkg::STATUS_OK);
                    end
                endcase
            end else if (func == dehv_pkg::FUNC_END) begin
                if (busy) begin
                    busy = 1'b0;
                    mode = dehv_pkg::MODE_IDLE;
                    acc = '0;
                    shift = '0;
                    left = '0;
                    n_read_errors++;
                    add_expected('0, dehv_pkg::STATUS_ERR);
                end
            end else if (func == dehv_pkg::FUNC_DATA && busy) begin
                if (mode == dehv_pkg::MODE_ULEB || mode == dehv_pkg::MODE_SLEB) begin
                    // seven payload bits per byte, nothing lands above bit 63
                    if (shift < 64) begin
                        acc |= {57'b0, b[6:0]} << shift;
                        next_shift = int'(shift) + dehv_pkg::LEB_BITS;
                        if (next_shift > dehv_pkg::SHIFT_STOP)
                            next_shift = dehv_pkg::SHIFT_STOP;
                        shift = SHW'(next_shift);
                    end
                    if (!b[7]) begin
                        if (mode == dehv_pkg::MODE_SLEB && b[6] && shift < 64)
                            acc |= {VW{1'b1}} << shift;
                        busy = 1'b0;
                        mode = dehv_pkg::MODE_IDLE;
                        n_values++;
                        add_expected(acc, dehv_pkg::STATUS_OK);
                    end
                end else begin
                    // fixed field, byte order from the swap register
                    if (swap) begin
                        acc = {acc[VW-9:0], b};
                    end else begin
                        if (shift < 64)
                            acc |= {56'b0, b} << shift;
                        next_shift = int'(shift) + 8;
                        if (next_shift > dehv_pkg::SHIFT_STOP)
                            next_shift = dehv_pkg::SHIFT_STOP;
                        shift = SHW'(next_shift);
                    end
                    if (left != 0)
                        left--;
                    if (left == 0) begin
                        case (mode)
                            dehv_pkg::MODE_FIX2: result = {{48{acc[15]}}, acc[15:0]};
                            dehv_pkg::MODE_FIX4: result = {{32{acc[31]}}, acc[31:0]};
                            default:             result = acc;
                        endcase
                        busy = 1'b0;
                        mode = dehv_pkg::MODE_IDLE;
                        n_values++;
                        add_expected(result, dehv_pkg::STATUS_OK);
                    end
                end
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // compare one output transfer with the oldest owed value
        task check_value(logic [VW-1:0] value, logic status);
            t_decode_result want;
            n_checked++;
            if (expected_values.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %h status %0b",
                                          value, status));
                return;
            end
            want = expected_values.pop_front();
            if (value !== want.value)
                report_mismatch($sformatf("value %h, wanted %h", value, want.value));
            if (status !== want.status)
                report_mismatch($sformatf("status %0b, wanted %0b", status, want.status));
        endtask
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic                           cfg_wdata = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [dehv_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [FW-1:0]                  s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [VW-1:0]                  m_tdata;
    logic                           m_tuser;

    value_scoreboard sb = new();
    bit steady = 1'b0;
    int accepted_items = 0;
    int noise_items = 0;
    int stuck_cycles = 0;

    dwarf_eh_value_decoder dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    // idle lengths: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // one input transfer; valid stays up when the next item follows at once
    task automatic send_item(logic [FW-1:0] func, logic [EW-1:0] enc,
                             logic [BW-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b, enc};
        s_tuser <= func;
        do @(posedge clk); while (!s_tready);
        sb.note_item(func, enc, b);
        accepted_items++;
    endtask

    // hold the sender until every owed value is out, then let the queue settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_swap(logic value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        sb.set_swap(value);
        cfg_we <= 1'b0;
    endtask

    // result side back-pressure
    initial begin
        int stall;
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // output transfer check
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_value(m_tdata, m_tuser);
    end

    // no transfer on either side for too long ends the run
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        logic [3:0]    code;
        logic [BW-1:0] data;
        int            nbytes;
        int            phase_start;
        bit            is_leb;
        bit            broken;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_swap(1'b0);

        // single-byte leb128 extremes and the sleb128 sign bit
        send_item(dehv_pkg::FUNC_BEGIN, {4'h0, dehv_pkg::ENC_ULEB}, 8'h00);
        send_item(dehv_pkg::FUNC_DATA, 8'hFF, 8'h7F);
        send_item(dehv_pkg::FUNC_BEGIN, {4'hF, dehv_pkg::ENC_SLEB}, 8'hFF);
        send_item(dehv_pkg::FUNC_DATA, 8'h00, 8'h40);
        // unknown encoding answers zero at once
        send_item(dehv_pkg::FUNC_BEGIN, {4'h0, ENC_UNKNOWN}, 8'h00);
        // ignored while idle: data byte, stream end, unused code
        send_item(dehv_pkg::FUNC_DATA, 8'h00, 8'hAA);
        send_item(dehv_pkg::FUNC_END, 8'h00, 8'h00);
        send_item(FUNC_UNUSED, 8'hFF, 8'hFF);
        // begin while busy drops the partial 8-byte field
        send_item(dehv_pkg::FUNC_BEGIN, {4'h0, dehv_pkg::ENC_SDAT8}, 8'h00);
        send_item(dehv_pkg::FUNC_DATA, 8'h00, 8'h11);
        send_item(dehv_pkg::FUNC_BEGIN, {4'h0, dehv_pkg::ENC_UDAT2}, 8'h00);
        send_item(dehv_pkg::FUNC_DATA, 8'h00, 8'hFF);
        send_item(dehv_pkg::FUNC_DATA, 8'h00, 8'h80);
        // stream end in the middle of a value
        send_item(dehv_pkg::FUNC_BEGIN, {4'h0, dehv_pkg::ENC_SDAT4}, 8'h00);
        send_item(dehv_pkg::FUNC_DATA, 8'h00, 8'h55);
        send_item(dehv_pkg::FUNC_END, 8'h00, 8'h00);
        // overlong sleb128: sign bit past bit 63 has no effect
        send_item(dehv_pkg::FUNC_BEGIN, {4'h0, dehv_pkg::ENC_SLEB}, 8'h00);
        repeat (10) send_item(dehv_pkg::FUNC_DATA, 8'h00, 8'hFF);
        send_item(dehv_pkg::FUNC_DATA, 8'h00, 8'h7F);

        // random phases, byte order alternating, two phases without idling
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            write_swap(1'(phase % 2));
            steady = (phase == 3 || phase == 6);
            phase_start = accepted_items - noise_items;
            while (accepted_items - noise_items - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 90) begin
                    // mostly well-formed values, some truncated ones
                    if ($urandom_range(0, 99) < 8)
                        code = 4'($urandom);
                    else
                        code = KNOWN_CODES[3'($urandom_range(0, 7))];
                    is_leb = (code == dehv_pkg::ENC_ULEB || code == dehv_pkg::ENC_SLEB);
                    case (code)
                        dehv_pkg::ENC_ULEB, dehv_pkg::ENC_SLEB:
                            nbytes = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 14)
                                                                  : $urandom_range(1, 4);
                        dehv_pkg::ENC_UDAT2, dehv_pkg::ENC_SDAT2:
                            nbytes = int'(dehv_pkg::FIX2_BYTES);
                        dehv_pkg::ENC_UDAT4, dehv_pkg::ENC_SDAT4:
                            nbytes = int'(dehv_pkg::FIX4_BYTES);
                        dehv_pkg::ENC_UDAT8, dehv_pkg::ENC_SDAT8:
                            nbytes = int'(dehv_pkg::FIX8_BYTES);
                        default:
                            nbytes = 0;
                    endcase
                    broken = (nbytes > 0) && ($urandom_range(0, 99) < 10);
                    if (broken)
                        nbytes = $urandom_range(0, nbytes - 1);
                    send_item(dehv_pkg::FUNC_BEGIN, {4'($urandom), code}, 8'($urandom));
                    for (int i = 0; i < nbytes; i++) begin
                        data = 8'($urandom);
                        if (is_leb)
                            data[7] = broken || (i != nbytes - 1);
                        send_item(dehv_pkg::FUNC_DATA, 8'($urandom), data);
                    end
                    if (broken && $urandom_range(0, 1) == 1)
                        send_item(dehv_pkg::FUNC_END, 8'($urandom), 8'($urandom));
                end else begin
                    // noise between values
                    case ($urandom_range(0, 2))
                        0:       send_item(FUNC_UNUSED, 8'($urandom), 8'($urandom));
                        1:       send_item(dehv_pkg::FUNC_END, 8'($urandom), 8'($urandom));
                        default: send_item(dehv_pkg::FUNC_DATA, 8'($urandom), 8'($urandom));
                    endcase
                    noise_items++;
                end
            end
            send_item(dehv_pkg::FUNC_END, 8'($urandom), 8'($urandom));
        end
        steady = 1'b0;
        drain();

        $display("run: %0d input transfers, %0d results checked, %0d phases, both byte orders",
                 accepted_items, sb.n_checked, NUM_PHASES);
        $display("run: %0d values, %0d unknown encodings, %0d stream-end errors, %0d mismatches",
                 sb.n_values, sb.n_unknown, sb.n_read_errors, sb.errors);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
